// ----- rtl/core/pal_pkg.sv -----
// Shared operation codes, status codes and result type for the positional array list.
package pal_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    FN_ADD_BACK   = 3'd0,
    FN_ADD_FRONT  = 3'd1,
    FN_INSERT     = 3'd2,
    FN_TAKE_BACK  = 3'd3,
    FN_TAKE_FRONT = 3'd4,
    FN_ERASE      = 3'd5,
    FN_READ       = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [WORD_W-1:0] word;
  } res_t;

endpackage

// ----- rtl/core/pal_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pal_ctrl.sv -----
// Sequencer that moves list entries one at a time through the entry RAM.
module pal_ctrl #(
  parameter int LIST_DEPTH = 64,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               func,
  input  logic [pal_pkg::WORD_W-1:0] value,
  input  logic [CNT_W-1:0]         position,
  input  logic                     res_ready,
  output pal_pkg::res_t            res,
  output logic [CNT_W-1:0]         count
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    IDLE,
    MOVE_RD,
    MOVE_WR,
    PUT,
    FETCH,
    GRAB,
    DONE
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            cur;
  logic [CNT_W-1:0]            op_at;
  logic                        op_open;
  logic [pal_pkg::WORD_W-1:0]  op_value;
  pal_pkg::status_t            status;
  logic [pal_pkg::WORD_W-1:0]  word;

  logic [CNT_W-1:0]            cur_inc;
  logic [CNT_W-1:0]            cur_dec;
  logic [CNT_W-1:0]            count_dec;
  logic [CNT_W-1:0]            at_sel;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [pal_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [pal_pkg::WORD_W-1:0]  ram_rdata;

  assign cur_inc   = cur + CNT_W'(1);
  assign cur_dec   = cur - CNT_W'(1);
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    case (pal_pkg::func_t'(func))
      pal_pkg::FN_ADD_BACK:   at_sel = count;
      pal_pkg::FN_INSERT:     at_sel = position;
      pal_pkg::FN_ERASE:      at_sel = position;
      default:                at_sel = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = op_open ? cur_dec[AW-1:0] : cur_inc[AW-1:0];
    case (state)
      MOVE_WR: begin
        ram_we = 1'b1;
      end
      PUT: begin
        ram_we    = 1'b1;
        ram_waddr = op_at[AW-1:0];
        ram_wdata = op_value;
      end
      FETCH: begin
        ram_raddr = op_at[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  pal_ram #(
    .WIDTH (pal_pkg::WORD_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            op_value <= value;
            word     <= '0;
            status   <= pal_pkg::ST_OK;
            state    <= DONE;
            case (pal_pkg::func_t'(func))
              pal_pkg::FN_ADD_BACK, pal_pkg::FN_ADD_FRONT, pal_pkg::FN_INSERT: begin
                if (count == DEPTH_C) begin
                  status <= pal_pkg::ST_FULL;
                end else if (pal_pkg::func_t'(func) == pal_pkg::FN_INSERT &&
                             position > count) begin
                  status <= pal_pkg::ST_BADPOS;
                end else begin
                  op_at   <= at_sel;
                  cur     <= count;
                  op_open <= 1'b1;
                  state   <= (count > at_sel) ? MOVE_RD : PUT;
                end
              end
              pal_pkg::FN_TAKE_BACK: begin
                if (count == '0) begin
                  status <= pal_pkg::ST_EMPTY;
                end else begin
                  count <= count_dec;
                end
              end
              pal_pkg::FN_TAKE_FRONT, pal_pkg::FN_ERASE: begin
                if (count == '0) begin
                  status <= pal_pkg::ST_EMPTY;
                end else if (position >= count &&
                             pal_pkg::func_t'(func) == pal_pkg::FN_ERASE) begin
                  status <= pal_pkg::ST_BADPOS;
                end else if (at_sel < count_dec) begin
                  cur     <= at_sel;
                  op_open <= 1'b0;
                  state   <= MOVE_RD;
                end else begin
                  count <= count_dec;
                end
              end
              pal_pkg::FN_READ: begin
                if (count == '0) begin
                  status <= pal_pkg::ST_EMPTY;
                end else if (position >= count) begin
                  status <= pal_pkg::ST_BADPOS;
                end else begin
                  op_at <= position;
                  state <= FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        MOVE_RD: begin
          state <= MOVE_WR;
        end
        MOVE_WR: begin
          if (op_open) begin
            cur   <= cur_dec;
            state <= (cur_dec > op_at) ? MOVE_RD : PUT;
          end else begin
            cur <= cur_inc;
            if (cur_inc < count_dec) begin
              state <= MOVE_RD;
            end else begin
              count <= count_dec;
              state <= DONE;
            end
          end
        end
        PUT: begin
          count <= count + CNT_W'(1);
          state <= DONE;
        end
        FETCH: begin
          state <= GRAB;
        end
        GRAB: begin
          word  <= ram_rdata;
          state <= DONE;
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state == IDLE);
  assign res.valid  = (state == DONE);
  assign res.status = status;
  assign res.word   = word;

endmodule

// ----- rtl/core/positional_array_list_top.sv -----
// Top level of the positional array list: sequencer plus registered result stage.
//
//   channel | signals                               | direction
//   input   | in_valid, in_ready, func, value, position | into the block
//   output  | out_valid, out_ready, status, fill_count, read_word | out of the block
//
// Pop back, the unused code and every error go straight to the result; push back writes the
// new entry, and a read fetches the word from the RAM. Push front and insert first move each
// entry above the position up one slot; pop front and erase move each later entry down one
// slot, so a push front on LIST_DEPTH - 1 entries is the worst case.
// Reset clears the fill count and the control state; entry contents are not cleared.
// The next item is taken while a result waits in the output register.
module positional_array_list_top #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           func,
  input  logic signed [31:0]                   value,
  input  logic [$clog2(LIST_DEPTH + 1)-1:0]    position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [$clog2(LIST_DEPTH + 1)-1:0]    fill_count,
  output logic signed [31:0]                   read_word
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  pal_pkg::res_t    res;
  logic [CNT_W-1:0] count;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;

  pal_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .value     (value),
    .position  (position),
    .res_ready (slot_free),
    .res       (res),
    .count     (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res.valid;
      if (res.valid) begin
        status     <= res.status;
        fill_count <= count;
        read_word  <= res.word;
      end
    end
  end

endmodule

// ----- bench/positional_array_list_top_tb.sv -----
// Self-checking testbench for the positional array list: directed table, biased random ops.
module positional_array_list_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 64;
  localparam int POS_W = $clog2(LIST_DEPTH + 1);
  localparam logic [2:0] FN_NOP = 3'd7;
  localparam int RANDOM_OPS = 500;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

  typedef struct packed {
    pal_pkg::status_t st;
    logic [POS_W-1:0] fill;
    logic [31:0]      word;
  } list_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [31:0]      val;
    logic [POS_W-1:0] pos;
    logic             typed;
    list_result_t     res;
  } list_step_t;

  localparam int NUM_DIRECTED = 23;
  localparam list_step_t DIRECTED [NUM_DIRECTED] = '{
    '{pal_pkg::FN_TAKE_BACK,  32'h0, 7'd0,   1'b1, '{pal_pkg::ST_EMPTY,  7'd0, 32'h0}},
    '{pal_pkg::FN_TAKE_FRONT, 32'h0, 7'd0,   1'b1, '{pal_pkg::ST_EMPTY,  7'd0, 32'h0}},
    '{pal_pkg::FN_ERASE,      32'h0, 7'd0,   1'b1, '{pal_pkg::ST_EMPTY,  7'd0, 32'h0}},
    '{pal_pkg::FN_READ,       32'h0, 7'd0,   1'b1, '{pal_pkg::ST_EMPTY,  7'd0, 32'h0}},
    '{FN_NOP,         32'h1234_5678, 7'd3,   1'b1, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{pal_pkg::FN_INSERT,     32'h1, 7'd1,   1'b1, '{pal_pkg::ST_BADPOS, 7'd0, 32'h0}},
    '{pal_pkg::FN_ADD_BACK,   32'h7fff_ffff, 7'd0, 1'b1, '{pal_pkg::ST_OK, 7'd1, 32'h0}},
    '{pal_pkg::FN_ADD_FRONT,  32'h8000_0000, 7'd0, 1'b1, '{pal_pkg::ST_OK, 7'd2, 32'h0}},
    '{pal_pkg::FN_INSERT,     32'hffff_ffff, 7'd2, 1'b1, '{pal_pkg::ST_OK, 7'd3, 32'h0}},
    '{pal_pkg::FN_INSERT,     32'h0, 7'd1,   1'b1, '{pal_pkg::ST_OK,     7'd4, 32'h0}},
    '{pal_pkg::FN_READ,       32'h0, 7'd0,   1'b1, '{pal_pkg::ST_OK, 7'd4, 32'h8000_0000}},
    '{pal_pkg::FN_READ,       32'h0, 7'd3,   1'b1, '{pal_pkg::ST_OK, 7'd4, 32'hffff_ffff}},
    '{pal_pkg::FN_READ,       32'h0, 7'd4,   1'b1, '{pal_pkg::ST_BADPOS, 7'd4, 32'h0}},
    '{pal_pkg::FN_READ,       32'hffff_ffff, 7'd127, 1'b1, '{pal_pkg::ST_BADPOS, 7'd4, 32'h0}},
    '{pal_pkg::FN_ERASE,      32'h0, 7'd4,   1'b1, '{pal_pkg::ST_BADPOS, 7'd4, 32'h0}},
    '{pal_pkg::FN_INSERT,     32'h2, 7'd5,   1'b1, '{pal_pkg::ST_BADPOS, 7'd4, 32'h0}},
    '{pal_pkg::FN_ERASE,      32'h0, 7'd1,   1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{pal_pkg::FN_TAKE_FRONT, 32'h0, 7'd0,   1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{pal_pkg::FN_READ,       32'h0, 7'd0,   1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{pal_pkg::FN_TAKE_BACK,  32'h0, 7'd0,   1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{pal_pkg::FN_INSERT,     32'h5555_aaaa, 7'd0, 1'b0, '{pal_pkg::ST_OK, 7'd0, 32'h0}},
    '{pal_pkg::FN_READ,       32'h0, 7'd0,   1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}},
    '{FN_NOP,         32'hffff_ffff, 7'd127, 1'b0, '{pal_pkg::ST_OK,     7'd0, 32'h0}}
  };

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               func;
  logic signed [31:0]       value;
  logic [POS_W-1:0]         position;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic [POS_W-1:0]         fill_count;
  logic signed [31:0]       read_word;

  logic signed [31:0]       list_words [LIST_DEPTH];
  int unsigned              list_len;
  list_result_t             list_results [$];
  int                       send_idle_pct;
  int                       recv_idle_pct;
  int                       holds_asked;
  int                       mismatches;
  bit                       growing;

  positional_array_list_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .fill_count(fill_count),
    .read_word (read_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [31:0] v,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned slot;
    r.st = pal_pkg::ST_OK;
    r.word = '0;
    case (op)
      pal_pkg::FN_ADD_BACK, pal_pkg::FN_ADD_FRONT, pal_pkg::FN_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.st = pal_pkg::ST_FULL;
        end else if (op == pal_pkg::FN_INSERT && pos > list_len) begin
          r.st = pal_pkg::ST_BADPOS;
        end else begin
          slot = (op == pal_pkg::FN_ADD_BACK) ? list_len :
                 (op == pal_pkg::FN_ADD_FRONT) ? 0 : pos;
          for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = v;
          list_len++;
        end
      end
      pal_pkg::FN_TAKE_BACK, pal_pkg::FN_TAKE_FRONT: begin
        if (list_len == 0) begin
          r.st = pal_pkg::ST_EMPTY;
        end else begin
          if (op == pal_pkg::FN_TAKE_FRONT) begin
            for (int i = 0; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          end
          list_len--;
        end
      end
      pal_pkg::FN_ERASE, pal_pkg::FN_READ: begin
        if (list_len == 0) begin
          r.st = pal_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          r.st = pal_pkg::ST_BADPOS;
        end else if (op == pal_pkg::FN_READ) begin
          r.word = list_words[pos];
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    r.fill = list_len[POS_W-1:0];
    return r;
  endfunction

  task automatic offer_list_op(input logic [2:0] op, input logic [31:0] v,
                               input logic [POS_W-1:0] pos, input logic typed,
                               input list_result_t typed_res);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    value <= v;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(op, v, pos);
    list_results.insert(list_results.size(), typed ? typed_res : predicted);
  endtask

  task automatic offer_random_op();
    logic [2:0] op;
    logic [POS_W-1:0] pos;
    int kind;
    kind = $urandom_range(99);
    if (list_len == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
    if (list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
    if (kind < 2) begin
      op = FN_NOP;
    end else if (kind < (growing ? 70 : 30)) begin
      op = 3'($urandom_range(2));
    end else begin
      op = 3'($urandom_range(6, 3));
    end
    if ($urandom_range(9) == 0) begin
      pos = POS_W'($urandom_range(2 ** POS_W - 1));
    end else if (op == pal_pkg::FN_INSERT) begin
      pos = POS_W'($urandom_range(list_len));
    end else if (list_len > 0) begin
      pos = POS_W'($urandom_range(list_len - 1));
    end else begin
      pos = '0;
    end
    offer_list_op(op, $urandom, pos, 1'b0, '0);
  endtask

  task automatic wait_list_idle();
    in_valid <= 1'b0;
    while (list_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (list_results.size() == 0) begin
        $error("unexpected result: status %0d fill_count %0d read_word %0h",
               status, fill_count, read_word);
        mismatches++;
      end else begin
        want = list_results[0];
        list_results.delete(0);
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatches++;
        end
        if (fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
          mismatches++;
        end
        if (read_word !== want.word) begin
          $error("read_word: expected %0h, got %0h", want.word, read_word);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = pal_pkg::FN_ADD_BACK;
    value = '0;
    position = '0;
    list_len = 0;
    mismatches = 0;
    holds_asked = 0;
    growing = 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 79;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) begin
      offer_list_op(DIRECTED[k].op, DIRECTED[k].val, DIRECTED[k].pos,
                    DIRECTED[k].typed, DIRECTED[k].res);
    end
    for (int n = 0; n < RANDOM_OPS; n++) offer_random_op();

    wait_list_idle();
    send_idle_pct = 79;
    recv_idle_pct = 30;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 2) holds_asked++;
      offer_random_op();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 100 || n == 350) holds_asked++;
      if (n == 250) wait_list_idle();
      offer_random_op();
    end

    wait_list_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS positional_array_list_top");
    end else begin
      $display("FAIL positional_array_list_top");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL positional_array_list_top");
    $finish;
  end

endmodule
